// ===== sv/sbus_frame_receiver_unit_assert.svh =====
// Assertion macros for the SBUS frame receiver.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef SBUS_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define SFR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbus frame receiver: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbus frame receiver: next-cycle check failed");

`endif

// ===== sv/sfr_pkg.sv =====
// Shared types and constants of the SBUS frame receiver.
// Depends on nothing; used by every module of the block.
package sfr_pkg;

    localparam int FRAME_LENGTH  = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_BITS  = 11;

    // Data bytes 1..22 plus the flag byte are kept; header and footer are not.
    localparam int DATA_BYTES  = FRAME_LENGTH - 3;
    localparam int DATA_BITS   = DATA_BYTES * 8;
    localparam int STORE_BITS  = (FRAME_LENGTH - 2) * 8;
    localparam int FLAG_BITS   = 4;
    localparam int POS_W       = 5;
    localparam int CHAN_W      = 4;

    localparam logic [POS_W-1:0]  POS_HUNT   = '0;
    localparam logic [POS_W-1:0]  POS_FOOTER = POS_W'(FRAME_LENGTH - 1);
    localparam logic [CHAN_W-1:0] LAST_CHAN  = CHAN_W'(CHANNEL_COUNT - 1);

    // Frame queue between the parser and the unpacker.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;

    localparam logic [7:0] HEADER_RESET = 8'h0F;
    localparam logic [7:0] FOOTER_RESET = 8'h00;

    // One checked frame: packed channel bits and the low flag bits.
    typedef struct packed {
        logic [FLAG_BITS-1:0] flags;
        logic [DATA_BITS-1:0] data;
    } frame_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== sv/sbus_frame_receiver_unit.sv =====
// SBUS frame receiver: one byte accepted per cycle while the two-frame queue has room.
// A good footer byte puts the frame in the queue; the unpacker takes it when free and
// registers the beats out, one per cycle while pop keeps up (16 per frame).
// Throughput: a byte per cycle in unless full; a beat per cycle out while popped.
// Reset: asynchronous, active low; hunts for the header, registers take 0x0F and 0x00,
// queue and output are empty. The frame store itself is not cleared.
`include "sbus_frame_receiver_unit_assert.svh"

module sbus_frame_receiver_unit
    import sfr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]              cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              rx_byte,
    output logic                    empty,
    input  logic                    pop,
    output logic [CHAN_W-1:0]       channel_index,
    output logic [CHANNEL_BITS-1:0] channel_value,
    output logic                    digital_ch17,
    output logic                    digital_ch18,
    output logic                    lost_frame,
    output logic                    failsafe_on,
    output logic                    last_channel
);

    fifo_status_t fifo_stat;
    frame_t       push_frame;
    frame_t       head_frame;
    logic         frame_push;
    logic         fifo_pop;
    logic         byte_accept;

    // Bytes are held off only while the frame queue is full.
    assign cfg_ready   = 1'b1;
    assign full        = fifo_stat.full;
    assign byte_accept = push && !full;

    sfr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .frame_push  (frame_push),
        .frame_out   (push_frame)
    );

    sfr_frame_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (frame_push),
        .wr_frame (push_frame),
        .rd_en    (fifo_pop),
        .rd_frame (head_frame),
        .status   (fifo_stat)
    );

    sfr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_status   (fifo_stat),
        .fifo_frame    (head_frame),
        .fifo_pop      (fifo_pop),
        .pop           (pop),
        .empty         (empty),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .digital_ch17  (digital_ch17),
        .digital_ch18  (digital_ch18),
        .lost_frame    (lost_frame),
        .failsafe_on   (failsafe_on),
        .last_channel  (last_channel)
    );

    // The queue is never both full and empty.
    `SFR_ASSERT_IMPLIES(a_fifo_state, fifo_stat.full, !fifo_stat.empty)
    // The last beat of a frame always carries the last channel number.
    `SFR_ASSERT_IMPLIES(a_last_index, !empty && last_channel, channel_index == LAST_CHAN)
    // Within a frame, a taken beat is followed at once by the next one.
    `SFR_ASSERT_NEXT(a_no_gap, pop && !empty && !last_channel, !empty)

endmodule

// ===== sv/sfr_frame_fifo.sv =====
// Two-entry queue of checked frames between the parser and the unpacker.
// Depends on sfr_pkg for frame_t, fifo_status_t and the queue sizes.
module sfr_frame_fifo
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  frame_t       wr_frame,
    input  logic         rd_en,
    output frame_t       rd_frame,
    output fifo_status_t status
);

    frame_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    do_wr;
    logic                    do_rd;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_frame     = mem_reg[rd_ptr_reg];

    // Occupancy follows the two sides independently.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

// ===== sv/sfr_front.sv =====
// Front end: configuration registers, header hunt, byte collection and footer check.
// Depends on sfr_pkg for frame_t, positions and register indexes.
module sfr_front
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 byte_accept,
    input  logic [7:0]           rx_byte,
    output logic                 frame_push,
    output frame_t               frame_out
);

    logic [7:0]            header_reg;
    logic [7:0]            footer_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [STORE_BITS-1:0] store_reg;
    logic                  hunting;
    logic                  collecting;

    assign hunting    = (pos_reg == POS_HUNT) || (pos_reg > POS_FOOTER);
    assign collecting = !hunting && (pos_reg < POS_FOOTER);

    // A good footer hands the collected frame to the queue.
    assign frame_push      = byte_accept && (pos_reg == POS_FOOTER) && (rx_byte == footer_reg);
    assign frame_out.data  = store_reg[DATA_BITS-1:0];
    assign frame_out.flags = store_reg[DATA_BITS +: FLAG_BITS];

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_FOOTER: footer_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Frame position: hunt, collect, then the footer returns to hunting.
    always_comb
    begin
        pos_next = pos_reg;
        if (byte_accept)
        begin
            if (hunting)
            begin
                pos_next = (rx_byte == header_reg) ? POS_W'(1) : POS_HUNT;
            end
            else if (collecting)
            begin
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                pos_next = POS_HUNT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Bytes shift in from the top, so the first data byte ends at bit zero.
    always_ff @(posedge clk)
    begin
        if (byte_accept && collecting)
        begin
            store_reg <= {rx_byte, store_reg[STORE_BITS-1:8]};
        end
    end

endmodule

// ===== sv/sfr_back.sv =====
// Back end: unpacks one queued frame into sixteen channel beats through an output register.
// Depends on sfr_pkg for frame_t, fifo_status_t and channel constants.
module sfr_back
    import sfr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fifo_status_t            fifo_status,
    input  frame_t                  fifo_frame,
    output logic                    fifo_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic [CHAN_W-1:0]       channel_index,
    output logic [CHANNEL_BITS-1:0] channel_value,
    output logic                    digital_ch17,
    output logic                    digital_ch18,
    output logic                    lost_frame,
    output logic                    failsafe_on,
    output logic                    last_channel
);

    logic                    busy_reg;
    logic [CHAN_W-1:0]       chan_reg;
    logic [DATA_BITS-1:0]    shift_reg;
    logic [FLAG_BITS-1:0]    flags_reg;
    logic                    out_valid_reg;
    logic [CHAN_W-1:0]       out_index_reg;
    logic [CHANNEL_BITS-1:0] out_value_reg;
    logic [FLAG_BITS-1:0]    out_flags_reg;
    logic                    out_last_reg;
    logic                    advance;
    logic                    frame_done;

    // A channel moves to the output register whenever that register is free or draining.
    assign advance    = busy_reg && (!out_valid_reg || pop);
    assign frame_done = advance && (chan_reg == LAST_CHAN);
    assign fifo_pop   = (!busy_reg || frame_done) && !fifo_status.empty;

    assign empty         = !out_valid_reg;
    assign channel_index = out_index_reg;
    assign channel_value = out_value_reg;
    assign digital_ch17  = out_flags_reg[0];
    assign digital_ch18  = out_flags_reg[1];
    assign lost_frame    = out_flags_reg[2];
    assign failsafe_on   = out_flags_reg[3];
    assign last_channel  = out_last_reg;

    // Control: frame in progress, channel counter, output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fifo_pop)
            begin
                busy_reg <= 1'b1;
                chan_reg <= '0;
            end
            else if (frame_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                chan_reg <= chan_reg + 1'b1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: the lowest eleven bits leave first, then the word shifts down.
    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            shift_reg <= fifo_frame.data;
            flags_reg <= fifo_frame.flags;
        end
        else if (advance)
        begin
            shift_reg <= shift_reg >> CHANNEL_BITS;
        end

        if (advance)
        begin
            out_index_reg <= chan_reg;
            out_value_reg <= shift_reg[CHANNEL_BITS-1:0];
            out_flags_reg <= flags_reg;
            out_last_reg  <= (chan_reg == LAST_CHAN);
        end
    end

endmodule
